// ----- hw/rtl/flow_vector_color_coder_macros.svh -----
// Assertion macros for the flow vector color coder.
// Used by the top level only; needs a signal named clk and one named rst in scope.
`ifndef FLOW_VECTOR_COLOR_CODER_MACROS_SVH
`define FLOW_VECTOR_COLOR_CODER_MACROS_SVH

// Same-cycle implication.
`define FVCC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define FVCC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hw/rtl/fvcc_pkg.sv -----
// Shared constants, wheel table and controller/datapath interface types.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package fvcc_pkg;

  localparam int FLOW_FRAC_BITS = 8;
  localparam int WHEEL_SIZE     = 55;
  localparam int CORDIC_STEPS   = 14;
  localparam int ROOT_STEPS     = 32;
  localparam int DIV_STEPS      = 32;

  localparam logic [15:0] RUN_MAX_RESET = 16'(1 << FLOW_FRAC_BITS);

  // arctangent of 2^-i in units of 1/65536 turn
  localparam logic [15:0] ATAN_TURNS [CORDIC_STEPS] = '{
    16'd8192, 16'd4836, 16'd2555, 16'd1297, 16'd651, 16'd326, 16'd163,
    16'd81, 16'd41, 16'd20, 16'd10, 16'd5, 16'd3, 16'd1
  };

  // wheel entry: {red, green, blue}
  typedef logic [WHEEL_SIZE-1:0][23:0] wheel_tbl_t;

  function automatic wheel_tbl_t build_wheel();
    wheel_tbl_t tbl;
    int r;
    int g;
    int b;
    for (int k = 0; k < WHEEL_SIZE; k++) begin
      if (k < 15) begin
        r = 255; g = 255 * k / 15; b = 0;
      end else if (k < 21) begin
        r = 255 - 255 * (k - 15) / 6; g = 255; b = 0;
      end else if (k < 25) begin
        r = 0; g = 255; b = 255 * (k - 21) / 4;
      end else if (k < 36) begin
        r = 0; g = 255 - 255 * (k - 25) / 11; b = 255;
      end else if (k < 49) begin
        r = 255 * (k - 36) / 13; g = 0; b = 255;
      end else begin
        r = 255; g = 0; b = 255 - 255 * (k - 49) / 6;
      end
      tbl[k] = {8'(r), 8'(g), 8'(b)};
    end
    return tbl;
  endfunction

  localparam wheel_tbl_t WHEEL = build_wheel();

  typedef struct packed {
    logic       load;
    logic       sq_x;
    logic       sq_y;
    logic       root_step;
    logic       cordic_step;
    logic [3:0] idx;
    logic       meas_upd;
    logic       div_step;
    logic       hue_c;
    logic       hue_o;
    logic [1:0] ch;
    logic       out_load;
  } fvcc_cmd_t;

  typedef struct packed {
    logic paint;
    logic vec_ok;
  } fvcc_stat_t;

endpackage
`default_nettype wire

// ----- hw/rtl/fvcc_dp.sv -----
// Datapath: squares, digit-by-digit root, CORDIC phase, divider, hue blend.
// Depends on fvcc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module fvcc_dp (
  input  wire                     clk,
  input  wire                     rst,
  input  fvcc_pkg::fvcc_cmd_t     cmd,
  output fvcc_pkg::fvcc_stat_t    stat,
  input  wire                     operation,
  input  wire                     frame_start,
  input  wire signed [15:0]       flow_x,
  input  wire signed [15:0]       flow_y,
  input  wire                     flow_valid,
  input  wire [15:0]              max_motion,
  output logic [7:0]              red,
  output logic [7:0]              green,
  output logic [7:0]              blue
);
  import fvcc_pkg::*;

  logic               paint;
  logic               vec_ok;
  logic signed [15:0] fx;
  logic signed [15:0] fy;
  logic [30:0]        sqx;
  logic [31:0]        sum;
  logic [31:0]        ss;
  logic [63:0]        v;
  logic [33:0]        rem;
  logic [31:0]        root;
  logic signed [31:0] cx;
  logic signed [31:0] cy;
  logic [15:0]        phase;
  logic               axis;
  logic [15:0]        run_max;
  logic [16:0]        drem;
  logic [5:0]         k0;
  logic [15:0]        f;
  logic               in_scale;
  logic [16:0]        r17;
  logic [23:0]        cval;
  logic [7:0]         col [3];

  logic [15:0]        scale;
  logic signed [31:0] prod_x;
  logic signed [31:0] prod_y;
  logic [31:0]        sum_next;
  logic [34:0]        rem_sh;
  logic [34:0]        trial;
  logic signed [31:0] dxs;
  logic signed [31:0] dys;
  logic [16:0]        rc;
  logic [17:0]        d_sh;
  logic [21:0]        t;
  logic [5:0]         k1;
  logic [23:0]        w0;
  logic [23:0]        w1;
  logic [7:0]         w0b;
  logic [7:0]         w1b;
  logic [23:0]        diff;
  logic [40:0]        prod;
  logic [40:0]        blend;
  logic [25:0]        dim;
  logic signed [16:0] nx;
  logic signed [16:0] ny;

  assign stat.paint  = paint;
  assign stat.vec_ok = vec_ok;

  always_comb begin
    scale = (max_motion != 16'd0) ? max_motion : run_max;
    if (scale == 16'd0) scale = 16'd1;
  end

  assign prod_x   = fx * fx;
  assign prod_y   = fy * fy;
  assign sum_next = 32'(sqx) + 32'(prod_y[30:0]);
  assign rem_sh   = {rem[32:0], v[63:62]};
  assign trial    = {1'b0, root, 2'b01};
  assign dxs      = cy >>> cmd.idx;
  assign dys      = cx >>> cmd.idx;
  assign rc       = 17'(root[15:0]) + 17'(rem != 34'd0);
  assign d_sh     = {drem, root[31]};
  assign t        = 22'(phase) * 22'd54;
  assign k1       = (k0 == 6'(WHEEL_SIZE - 1)) ? 6'd0 : k0 + 6'd1;
  assign w0       = WHEEL[k0];
  assign w1       = WHEEL[k1];
  assign diff     = {8'd255, 16'd0} - cval;
  assign prod     = 41'(r17) * 41'(diff);
  assign blend    = {1'b0, 8'd255, 32'd0} - prod;
  assign dim      = 26'(cval) * 26'd3;
  assign nx       = flow_x[15] ? -17'(flow_x) : 17'(flow_x);
  assign ny       = flow_x[15] ? -17'(flow_y) : 17'(flow_y);

  always_comb begin
    case (cmd.ch)
      2'd0:    begin w0b = w0[23:16]; w1b = w1[23:16]; end
      2'd1:    begin w0b = w0[15:8];  w1b = w1[15:8];  end
      default: begin w0b = w0[7:0];   w1b = w1[7:0];   end
    endcase
  end

  // running maximum is the only state kept across items
  always_ff @(posedge clk) begin
    if (rst) begin
      run_max <= RUN_MAX_RESET;
    end else if (cmd.load) begin
      if (!operation && frame_start) run_max <= RUN_MAX_RESET;
    end else if (cmd.meas_upd && vec_ok) begin
      if (rc > 17'hFFFF) begin
        run_max <= 16'hFFFF;
      end else if (rc[15:0] > run_max) begin
        run_max <= rc[15:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      paint  <= operation;
      vec_ok <= flow_valid;
      fx     <= flow_x;
      fy     <= flow_y;
      col    <= '{8'd0, 8'd0, 8'd0};
      cx     <= 32'(nx) <<< 14;
      cy     <= 32'(ny) <<< 14;
      if (flow_y == 16'sd0) begin
        axis  <= 1'b1;
        phase <= flow_x[15] ? 16'h8000 : 16'h0000;
      end else if (flow_x == 16'sd0) begin
        axis  <= 1'b1;
        phase <= flow_y[15] ? 16'hC000 : 16'h4000;
      end else begin
        axis  <= 1'b0;
        phase <= flow_x[15] ? 16'h8000 : 16'h0000;
      end
    end
    if (cmd.sq_x) begin
      sqx <= prod_x[30:0];
      ss  <= 32'(scale) * 32'(scale);
    end
    if (cmd.sq_y) begin
      sum  <= sum_next;
      v    <= paint ? {sum_next, 32'd0} : {32'd0, sum_next};
      rem  <= '0;
      root <= '0;
      drem <= '0;
    end
    if (cmd.root_step) begin
      v <= v << 2;
      if (rem_sh >= trial) begin
        rem  <= 34'(rem_sh - trial);
        root <= {root[30:0], 1'b1};
      end else begin
        rem  <= rem_sh[33:0];
        root <= {root[30:0], 1'b0};
      end
    end
    if (cmd.cordic_step && !axis) begin
      if (cy > 32'sd0) begin
        cx    <= cx + dxs;
        cy    <= cy - dys;
        phase <= phase + ATAN_TURNS[cmd.idx];
      end else begin
        cx    <= cx - dxs;
        cy    <= cy + dys;
        phase <= phase - ATAN_TURNS[cmd.idx];
      end
    end
    // quotient bits shift into root from the bottom
    if (cmd.div_step) begin
      k0       <= t[21:16];
      f        <= t[15:0];
      in_scale <= (sum <= ss);
      if (d_sh >= {2'b00, scale}) begin
        drem <= 17'(d_sh - {2'b00, scale});
        root <= {root[30:0], 1'b1};
      end else begin
        drem <= d_sh[16:0];
        root <= {root[30:0], 1'b0};
      end
    end
    if (cmd.hue_c) begin
      r17  <= (root > 32'h10000) ? 17'h10000 : root[16:0];
      cval <= 24'(25'(w0b) * 25'(17'h10000 - {1'b0, f}) + 25'(w1b) * 25'({1'b0, f}));
    end
    if (cmd.hue_o) begin
      col[cmd.ch] <= in_scale ? blend[39:32] : dim[25:18];
    end
    if (cmd.out_load) begin
      red   <= col[0];
      green <= col[1];
      blue  <= col[2];
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/fvcc_ctrl.sv -----
// Sequencer for the color coder datapath and owner of the output valid.
// Depends on fvcc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module fvcc_ctrl (
  input  wire                     clk,
  input  wire                     rst,
  input  wire                     in_valid,
  output logic                    in_stall,
  output logic                    out_valid,
  input  wire                     out_stall,
  input  fvcc_pkg::fvcc_stat_t    stat,
  output fvcc_pkg::fvcc_cmd_t     cmd
);
  import fvcc_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_SQX, S_SQY, S_ROOT, S_MEAS, S_DIV, S_HUEC, S_HUEO, S_DONE
  } state_t;

  state_t     state;
  logic [4:0] cnt;
  logic [1:0] ch;
  logic       out_free;

  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    cmd             = '0;
    cmd.load        = (state == S_IDLE) && in_valid;
    cmd.sq_x        = (state == S_SQX);
    cmd.sq_y        = (state == S_SQY);
    cmd.root_step   = (state == S_ROOT);
    cmd.cordic_step = (state == S_ROOT) && (cnt < 5'(CORDIC_STEPS));
    cmd.idx         = cnt[3:0];
    cmd.meas_upd    = (state == S_MEAS);
    cmd.div_step    = (state == S_DIV);
    cmd.hue_c       = (state == S_HUEC);
    cmd.hue_o       = (state == S_HUEO);
    cmd.ch          = ch;
    cmd.out_load    = (state == S_DONE) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      ch        <= '0;
      out_valid <= 1'b0;
    end else begin
      if ((state == S_DONE) && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) state <= S_SQX;
        end
        S_SQX: state <= S_SQY;
        S_SQY: begin
          cnt <= '0;
          if (stat.vec_ok) state <= S_ROOT;
          else if (stat.paint) state <= S_DONE;
          else state <= S_IDLE;
        end
        S_ROOT: begin
          cnt <= cnt + 5'd1;
          if (cnt == 5'(ROOT_STEPS - 1)) begin
            cnt   <= '0;
            state <= stat.paint ? S_DIV : S_MEAS;
          end
        end
        S_MEAS: state <= S_IDLE;
        S_DIV: begin
          cnt <= cnt + 5'd1;
          if (cnt == 5'(DIV_STEPS - 1)) begin
            ch    <= '0;
            state <= S_HUEC;
          end
        end
        S_HUEC: state <= S_HUEO;
        S_HUEO: begin
          if (ch == 2'd2) state <= S_DONE;
          else begin
            ch    <= ch + 2'd1;
            state <= S_HUEC;
          end
        end
        S_DONE: begin
          if (out_free) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/flow_vector_color_coder.sv -----
// Flow vector color coder top: APB register, controller and datapath.
// Depends on fvcc_pkg, fvcc_ctrl, fvcc_dp and flow_vector_color_coder_macros.svh.
//
// Turns Q8.8 motion vectors into RGB on the standard 55-entry color wheel.
// Measure words (operation 0) update the running maximum length and give no
// result; paint words (operation 1) give one color word. One word is worked
// on at a time. A valid paint word runs the squaring of x and y, 32 root digit
// steps with the 14 CORDIC steps running alongside, 32 divider steps, the blend
// of the three channels and a handoff to the output register, which waits while
// an earlier color is stalled there. A valid measure word runs the squaring, the
// root steps and a maximum update; an invalid word skips the root and divider
// steps. The next word is taken while a color waits in the output register.
// max_motion sits at byte address 0; zero selects the measured maximum.
`timescale 1ns / 1ps
`default_nettype none
`include "flow_vector_color_coder_macros.svh"
module flow_vector_color_coder (
  input  wire               clk,
  input  wire               rst,
  // input words
  input  wire               in_valid,
  output logic              in_stall,
  input  wire               operation,
  input  wire               frame_start,
  input  wire signed [15:0] flow_x,
  input  wire signed [15:0] flow_y,
  input  wire               flow_valid,
  // color words
  output logic              out_valid,
  input  wire               out_stall,
  output logic [7:0]        red,
  output logic [7:0]        green,
  output logic [7:0]        blue,
  // register port
  input  wire               psel,
  input  wire               penable,
  input  wire               pwrite,
  input  wire [1:0]         paddr,
  input  wire [31:0]        pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);
  import fvcc_pkg::*;

  localparam logic [1:0] ADDR_MAX_MOTION = 2'd0;

  logic [15:0] max_motion;
  logic        reg_wr;
  fvcc_cmd_t   cmd;
  fvcc_stat_t  stat;
  logic        in_take;
  logic        black_req;
  logic        out_black;

  assign pready = 1'b1;
  assign reg_wr = psel && penable && pwrite && (paddr == ADDR_MAX_MOTION);
  assign prdata = (paddr == ADDR_MAX_MOTION) ? {16'd0, max_motion} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_motion <= '0;
    end else if (reg_wr) begin
      max_motion <= pwdata[15:0];
    end
  end

  fvcc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  fvcc_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .operation   (operation),
    .frame_start (frame_start),
    .flow_x      (flow_x),
    .flow_y      (flow_y),
    .flow_valid  (flow_valid),
    .max_motion  (max_motion),
    .red         (red),
    .green       (green),
    .blue        (blue)
  );

  assign in_take   = in_valid && !in_stall;
  assign black_req = in_take && operation && !flow_valid && !out_valid;
  assign out_black = out_valid && (red == 8'd0) && (green == 8'd0) && (blue == 8'd0);

  // one word in flight: an accepted word always blocks the next cycle
  `FVCC_ASSERT_NEXT(a_one_word, in_take, in_stall, "second word taken while busy")

  // register write lands
  `FVCC_ASSERT_NEXT(a_reg_wr, reg_wr, max_motion == $past(pwdata[15:0]), "max_motion not written")

  // invalid paint word with a free output shows black after the SQX, SQY and DONE states
  `FVCC_ASSERT_NEXT(a_black, black_req, ##3 out_black, "invalid vector not black")

endmodule
`default_nettype wire

// ----- test/testbench.sv -----
// Self-checking bench for flow_vector_color_coder: a queued word driver, a color
// monitor and an in-bench color wheel predictor. Depends on the block's RTL only.
`timescale 1ns / 1ps
module testbench;

  localparam logic       OP_MEASURE      = 1'b0;
  localparam logic       OP_PAINT        = 1'b1;
  localparam logic [1:0] MAX_MOTION_ADDR = 2'd0;
  localparam int         DRAIN_CYCLES    = 120;  // longer than a paint word's run through the block
  localparam int         HOLD_CYCLES     = 900;

  typedef struct {
    logic               op;
    logic               start;
    logic signed [15:0] fx;
    logic signed [15:0] fy;
    logic               ok;
  } flow_word_t;

  typedef struct {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } color_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic operation = 1'b0;
  logic frame_start = 1'b0;
  logic signed [15:0] flow_x = '0;
  logic signed [15:0] flow_y = '0;
  logic flow_valid = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [7:0] red, green, blue;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  flow_vector_color_coder dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state, mirrored from the block
  logic [15:0] scale_reg;
  logic [15:0] run_max;

  flow_word_t pending_words[$];
  color_t     expected_colors[$];
  int send_idle_pct = 0;
  int stall_pct = 0;
  int mismatches = 0;
  int colors_seen = 0;
  int words_sent = 0;
  logic hold_go = 1'b0;

  function automatic int wheel_byte(int k, int ch);
    int r, g, b;
    r = 0; g = 0; b = 0;
    if (k < 15) begin
      r = 255; g = 255 * k / 15;
    end else if (k < 21) begin
      r = 255 - 255 * (k - 15) / 6; g = 255;
    end else if (k < 25) begin
      g = 255; b = 255 * (k - 21) / 4;
    end else if (k < 36) begin
      g = 255 - 255 * (k - 25) / 11; b = 255;
    end else if (k < 49) begin
      r = 255 * (k - 36) / 13; b = 255;
    end else if (k < 55) begin
      r = 255; b = 255 - 255 * (k - 49) / 6;
    end
    return ch == 0 ? r : (ch == 1 ? g : b);
  endfunction

  function automatic logic [63:0] root_floor(logic [63:0] v);
    logic [63:0] res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // direction in 1/65536 turn; vectoring CORDIC with floor shifts
  function automatic logic [15:0] flow_angle(longint x, longint y);
    longint atan_lut [14] = '{8192, 4836, 2555, 1297, 651, 326, 163, 81, 41, 20, 10, 5, 3, 1};
    longint xs, ys, dx, dy, acc, base;
    acc = 0; base = 0;
    if (y == 0) return x < 0 ? 16'd32768 : 16'd0;
    if (x == 0) return y > 0 ? 16'd16384 : 16'd49152;
    if (x < 0) begin
      x = -x; y = -y; base = 32768;
    end
    xs = x * 16384;
    ys = y * 16384;
    for (int i = 0; i < 14; i++) begin
      dx = ys >>> i;
      dy = xs >>> i;
      if (ys > 0) begin
        xs += dx; ys -= dy; acc += atan_lut[i];
      end else begin
        xs -= dx; ys += dy; acc -= atan_lut[i];
      end
    end
    return 16'(base + acc);
  endfunction

  // Updates the running maximum on measure words; returns 1 and the color on paint words.
  function automatic bit code_vector(flow_word_t w, output color_t col);
    longint fx, fy;
    logic [63:0] sum, rc, scale, r, c, t, ch_val;
    logic [15:0] ph;
    int k0, k1, f;
    logic [7:0] chans [3];
    fx = w.fx; fy = w.fy;
    sum = 64'(fx * fx + fy * fy);
    col = '{8'd0, 8'd0, 8'd0};
    if (w.op == OP_MEASURE) begin
      if (w.start) run_max = 16'd256;
      if (w.ok) begin
        rc = root_floor(sum);
        if (rc * rc < sum) rc++;
        if (rc > 64'hFFFF) rc = 64'hFFFF;
        if (rc > run_max) run_max = 16'(rc);
      end
      return 0;
    end
    if (!w.ok) return 1;   // invalid vector paints black
    scale = scale_reg != 0 ? scale_reg : run_max;
    if (scale == 0) scale = 1;
    ph = flow_angle(fx, fy);
    t = 64'(ph) * 54;
    k0 = int'(t >> 16);
    f = int'(t[15:0]);
    k1 = (k0 + 1) % 55;
    r = root_floor(sum << 32) / scale;
    if (r > 65536) r = 65536;
    for (int ch = 0; ch < 3; ch++) begin
      c = 64'(wheel_byte(k0, ch)) * (65536 - f) + 64'(wheel_byte(k1, ch)) * f;
      if (sum <= scale * scale)
        ch_val = ((64'd255 << 32) - r * ((64'd255 << 16) - c)) >> 32;
      else
        ch_val = (3 * c) >> 18;   // beyond the scale: dimmed to 0.75
      chans[ch] = ch_val[7:0];
    end
    col = '{chans[0], chans[1], chans[2]};
    return 1;
  endfunction

  // Driver: prediction happens at acceptance, so it sees the config in force then.
  always @(posedge clk) begin
    flow_word_t w, cur;
    color_t col;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        cur = '{operation, frame_start, flow_x, flow_y, flow_valid};
        if (code_vector(cur, col)) expected_colors.push_back(col);
        words_sent++;
      end
      if (!in_valid || !in_stall) begin
        if (pending_words.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          w = pending_words.pop_front();
          operation   <= w.op;
          frame_start <= w.start;
          flow_x      <= w.fx;
          flow_y      <= w.fy;
          flow_valid  <= w.ok;
          in_valid    <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver stall, with one long hold-off so the block backs up into its input.
  int  hold_left = 0;
  bit  hold_used = 0;
  always @(posedge clk) begin
    if (hold_go && !hold_used) begin
      hold_used <= 1;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= $urandom_range(99) < stall_pct;
    end
  end

  // Monitor
  always @(posedge clk) begin
    color_t exp_col;
    if (!rst && out_valid && !out_stall) begin
      colors_seen++;
      if (expected_colors.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected color word %h %h %h", red, green, blue);
      end else begin
        exp_col = expected_colors.pop_front();
        if (exp_col.red !== red || exp_col.green !== green || exp_col.blue !== blue) begin
          mismatches++;
          if (mismatches <= 10)
            $display("color mismatch: expected %h %h %h, got %h %h %h",
                     exp_col.red, exp_col.green, exp_col.blue, red, green, blue);
        end
      end
    end
  end

  task automatic apb_write(logic [1:0] addr, logic [31:0] data);
    @(posedge clk);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0; paddr <= addr; pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  task automatic set_scale(logic [15:0] v);
    apb_write(MAX_MOTION_ADDR, {16'd0, v});
    scale_reg = v;
  endtask

  task automatic push_word(logic op, logic start, int fx, int fy, logic ok);
    flow_word_t w;
    w = '{op, start, 16'(fx), 16'(fy), ok};
    pending_words.push_back(w);
  endtask

  task automatic drain();
    while (pending_words.size() > 0 || in_valid || expected_colors.size() > 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic int rand_comp();
    if ($urandom_range(3) == 0) return $signed(16'($urandom()));
    return int'($urandom_range(4095)) - 2048;
  endfunction

  // Frames: measure pass opening with frame_start, then paint pass over the same
  // vectors; about one pick in ten is a single free noise word instead of a frame.
  task automatic random_frames(int n_words);
    int fxs [8], fys [8];
    bit oks [8];
    int len, cnt;
    cnt = 0;
    while (cnt < n_words) begin
      if ($urandom_range(9) == 0) begin
        push_word($urandom_range(1), $urandom_range(1), rand_comp(), rand_comp(),
                  $urandom_range(1));
        cnt++;
      end else begin
        len = $urandom_range(8, 1);
        for (int i = 0; i < len; i++) begin
          fxs[i] = rand_comp(); fys[i] = rand_comp(); oks[i] = $urandom_range(15) != 0;
          if ($urandom_range(19) == 0) fxs[i] = 0;
          if ($urandom_range(19) == 0) fys[i] = 0;
          push_word(OP_MEASURE, i == 0, fxs[i], fys[i], oks[i]);
        end
        for (int i = 0; i < len; i++)
          push_word(OP_PAINT, $urandom_range(1), fxs[i], fys[i], oks[i]);
        cnt += 2 * len;
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    scale_reg = 16'd0;
    run_max = 16'd256;

    // directed: extremes, axes, zero vector, invalid words, ignored frame_start
    set_scale(16'd0);
    push_word(OP_PAINT, 0, 100, 50, 1);          // scale still 1.0 from reset
    push_word(OP_MEASURE, 1, 0, 0, 1);
    push_word(OP_MEASURE, 0, -32768, -32768, 1); // longest vector
    push_word(OP_PAINT, 0, -32768, -32768, 1);
    push_word(OP_PAINT, 0, 32767, 32767, 1);
    push_word(OP_PAINT, 0, 0, 0, 1);             // white
    push_word(OP_PAINT, 0, 300, 0, 1);
    push_word(OP_PAINT, 0, 0, 300, 1);
    push_word(OP_PAINT, 0, -300, 0, 1);
    push_word(OP_PAINT, 0, 0, -300, 1);
    push_word(OP_PAINT, 1, 5000, -7000, 0);      // black
    push_word(OP_MEASURE, 1, 32767, -32768, 0);  // reset only, no update
    push_word(OP_PAINT, 1, 200, 100, 1);         // frame_start ignored here
    push_word(OP_PAINT, 0, -1, 1, 1);
    push_word(OP_PAINT, 0, 1, -1, 1);
    push_word(OP_MEASURE, 0, 32767, 0, 1);
    push_word(OP_PAINT, 0, 32767, 0, 1);
    push_word(OP_PAINT, 0, -32768, 1, 1);
    drain();
    set_scale(16'hFFFF);
    push_word(OP_PAINT, 0, 32767, -32768, 1);
    push_word(OP_PAINT, 0, -20000, 15000, 1);
    drain();
    set_scale(16'd1);
    push_word(OP_PAINT, 0, 1, 0, 1);
    push_word(OP_PAINT, 0, 2, 3, 1);
    drain();

    // random phases under several scales and idling profiles
    set_scale(16'd0);
    send_idle_pct = 0; stall_pct = 0;
    hold_go <= 1'b1;
    random_frames(140);
    drain();
    set_scale(16'd256);
    send_idle_pct = 82; stall_pct = 0;
    random_frames(130);
    drain();
    set_scale(16'd0);
    send_idle_pct = 0; stall_pct = 82;
    random_frames(130);
    drain();
    set_scale(16'($urandom_range(65535, 1)));
    send_idle_pct = 10; stall_pct = 10;
    random_frames(70);
    drain();
    set_scale(16'hFFFF);
    random_frames(40);
    drain();

    $display("Sent %0d flow words over five scales and four idling profiles,", words_sent);
    $display("checked %0d color words, %0d mismatches.", colors_seen, mismatches);
    if (mismatches == 0 && expected_colors.size() == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

  initial begin
    #50ms;
    $display("Some tests failed");
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+hw/rtl
hw/rtl/fvcc_pkg.sv
hw/rtl/fvcc_dp.sv
hw/rtl/fvcc_ctrl.sv
hw/rtl/flow_vector_color_coder.sv
test/testbench.sv
